### rtl/core/tilt_pkg.sv
// Package for the tagged item location table.
// Holds table sizes, request and location codes, and the storage port structs.
// No dependencies; every module of the block imports it.
package tilt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int TYPE_BITS   = 4;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed port field widths.
  localparam int TAG_W     = 32;
  localparam int OPCODE_W  = 3;
  localparam int FTYPE_W   = 4;
  localparam int ECOUNT_W  = 6;
  localparam int LOC_W     = 2;

  // Request codes.
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REGISTER = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MARK_IN  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MARK_OUT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP   = 3'd5;

  // Location codes.
  localparam logic [LOC_W-1:0] LOC_UNKNOWN = 2'd0;
  localparam logic [LOC_W-1:0] LOC_INSIDE  = 2'd1;
  localparam logic [LOC_W-1:0] LOC_OUTSIDE = 2'd2;

  // One table entry as read from storage.
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [TYPE_BITS-1:0] ty;
    logic [LOC_W-1:0]     loc;
  } entry_t;

  // Write request into storage: whole entry or location only.
  typedef struct packed {
    logic                 en_entry;
    logic                 en_loc;
    logic [IDX_W-1:0]     addr;
    logic [TAG_W-1:0]     tag;
    logic [TYPE_BITS-1:0] ty;
    logic [LOC_W-1:0]     loc;
  } wr_req_t;

endpackage

### rtl/core/tagged_item_location_table_unit.sv
// Top level of the tagged item location table: request sequencer and result register.
// Scans the entry storage through one shared match unit.
// Depends on tilt_pkg, tilt_store and tilt_cmp.
//
// Usage:
//   Requests enter on the in_ channel (opcode, tag, type); a transfer happens
//   when in_valid is high and in_stall is low. Each request gives exactly one
//   result on the out_ channel (success, found type, entry count).
//   Clear and undefined opcodes finish without a scan: the request goes to
//   the done state, and from there its result is loaded into the output
//   register once that is free. Register, mark, query and lookup scan the
//   stored entries from index 0 upward, one entry per cycle through the single
//   read port of the storage and the one match unit, stopping at the first
//   match or after the last stored entry.
//   in_stall is high while a request is being worked on; one request is
//   handled at a time. A finished result waits in the output register while
//   out_stall is high; the next request may already be taken in, and its
//   completion holds until the output register is free.
//   The unknown type code is written through cfg_wr_en / cfg_wr_data; the user
//   must write it only while the block is idle, which the block does not enforce.
//   Reset empties the table and sets that code to zero; it needs no clearing pass.
module tagged_item_location_table_unit
  import tilt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [FTYPE_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [TAG_W-1:0]    in_tag_id,
  input  logic [FTYPE_W-1:0]  in_item_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_success,
  output logic [FTYPE_W-1:0]  out_found_type,
  output logic [ECOUNT_W-1:0] out_entry_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TYPE_BITS-1:0] unk_type_r;
  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [TYPE_BITS-1:0] ty_r, ty_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [FTYPE_W-1:0]   res_type_r, res_type_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [FTYPE_W-1:0]   out_type_r, out_type_nxt;
  logic [ECOUNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic                 in_xfer;
  logic                 issue;
  logic                 match;
  logic [IDX_W-1:0]     rd_addr;
  entry_t               rd_data;
  wr_req_t              wr;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign issue    = (scan_idx_r < count_r);
  assign rd_addr  = scan_idx_r[IDX_W-1:0];

  tilt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tilt_cmp u_cmp (
    .type_mode (op_r == OP_QUERY),
    .key_tag   (tag_r),
    .key_ty    (ty_r),
    .entry     (rd_data),
    .match     (match)
  );

  // Request sequencer.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    ty_nxt       = ty_r;
    scan_idx_nxt = scan_idx_r;
    chk_idx_nxt  = chk_idx_r;
    chk_vld_nxt  = chk_vld_r;
    res_ok_nxt   = res_ok_r;
    res_type_nxt = res_type_r;
    wr           = '0;
    wr.tag       = tag_r;
    wr.ty        = ty_r;
    wr.loc       = LOC_UNKNOWN;
    wr.addr      = chk_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt       = in_opcode;
          tag_nxt      = in_tag_id;
          ty_nxt       = TYPE_BITS'(in_item_type);
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          res_ok_nxt   = 1'b0;
          res_type_nxt = '0;
          case (in_opcode)
            OP_CLEAR: begin
              count_nxt  = '0;
              res_ok_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end
            OP_REGISTER, OP_MARK_IN, OP_MARK_OUT, OP_QUERY, OP_LOOKUP: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if ((chk_vld_r && match) || (!issue && !chk_vld_r)) begin
          // The scan has ended: hit at chk_idx_r, or a miss.
          state_nxt = ST_DONE;
          case (op_r)
            OP_REGISTER: begin
              if (!chk_vld_r && (count_r < CNT_W'(TABLE_DEPTH))) begin
                wr.en_entry = 1'b1;
                wr.addr     = count_r[IDX_W-1:0];
                wr.loc      = LOC_UNKNOWN;
                count_nxt   = CNT_W'(count_r + 1'b1);
                res_ok_nxt  = 1'b1;
              end
            end
            OP_MARK_IN, OP_MARK_OUT: begin
              if (chk_vld_r) begin
                wr.en_loc  = 1'b1;
                wr.loc     = (op_r == OP_MARK_IN) ? LOC_INSIDE : LOC_OUTSIDE;
                res_ok_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              res_ok_nxt = chk_vld_r;
            end
            OP_LOOKUP: begin
              res_ok_nxt   = chk_vld_r;
              res_type_nxt = chk_vld_r ? FTYPE_W'(rd_data.ty) : FTYPE_W'(unk_type_r);
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end else begin
          // Issue the next read while the previous entry is checked.
          if (issue) begin
            scan_idx_nxt = CNT_W'(scan_idx_r + 1'b1);
          end
          chk_vld_nxt = issue;
          chk_idx_nxt = rd_addr;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished request, freed by a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_type_nxt  = out_type_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok_r;
      out_type_nxt  = res_type_r;
      out_cnt_nxt   = ECOUNT_W'(count_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      unk_type_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unk_type_r <= TYPE_BITS'(cfg_wr_data);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    ty_r       <= ty_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_type_r <= res_type_nxt;
    out_ok_r   <= out_ok_nxt;
    out_type_r <= out_type_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_ok_r;
  assign out_found_type  = out_type_r;
  assign out_entry_count = out_cnt_r;

  // The entry count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The scan pointer never runs past the entry count.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= count_r))
    else $error("scan pointer beyond entry count");

  // Storage is written only when a scan ends.
  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en_entry || wr.en_loc) |-> (state_r == ST_SCAN))
    else $error("storage write outside a scan");

  // An accepted request keeps the input side closed in the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input open right after a transfer");

  // A new result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($past(out_ok_r) == out_ok_r) && out_valid_r)
    else $error("pending result overwritten");

endmodule

### rtl/core/tilt_store.sv
// Entry storage for the tagged item location table.
// One write port with per-field enables and one registered read port.
// Depends on tilt_pkg.
module tilt_store
  import tilt_pkg::*;
(
  input  logic             clk,
  input  wr_req_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  logic [TAG_W-1:0]     tag_mem  [TABLE_DEPTH];
  logic [TYPE_BITS-1:0] type_mem [TABLE_DEPTH];
  logic [LOC_W-1:0]     loc_mem  [TABLE_DEPTH];
  entry_t               rd_data_r;

  // Writes: a new entry sets all fields, a mark touches only the location.
  always_ff @(posedge clk) begin
    if (wr.en_entry) begin
      tag_mem[wr.addr]  <= wr.tag;
      type_mem[wr.addr] <= wr.ty;
    end
    if (wr.en_entry || wr.en_loc) begin
      loc_mem[wr.addr] <= wr.loc;
    end
  end

  // Registered read of one entry per cycle.
  always_ff @(posedge clk) begin
    rd_data_r.tag <= tag_mem[rd_addr];
    rd_data_r.ty  <= type_mem[rd_addr];
    rd_data_r.loc <= loc_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/tilt_cmp.sv
// Shared match unit of the tagged item location table.
// Compares one stored entry against the request key, by tag or by type.
// Depends on tilt_pkg.
module tilt_cmp
  import tilt_pkg::*;
(
  input  logic                 type_mode,
  input  logic [TAG_W-1:0]     key_tag,
  input  logic [TYPE_BITS-1:0] key_ty,
  input  entry_t               entry,
  output logic                 match
);

  // Type queries look for an entry of that type that is inside; all other
  // requests look for an equal tag.
  always_comb begin
    if (type_mode) begin
      match = (entry.ty == key_ty) && (entry.loc == LOC_INSIDE);
    end else begin
      match = (entry.tag == key_tag);
    end
  end

endmodule

### sim/tb.sv
// Testbench for the tagged item location table: directed table, then random request traffic.
// Results are checked against a behavioral table kept in this file.
// Depends on tilt_pkg and tagged_item_location_table_unit.
`timescale 1ns / 100ps

module tb;
  import tilt_pkg::*;

  // Opcodes that the block ignores.
  localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic [TAG_W-1:0] TAG_MAX = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASES = 6;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic                success;
    logic [FTYPE_W-1:0]  found_type;
    logic [ECOUNT_W-1:0] entry_count;
  } result_t;

  // One directed request; when typed is set, want is the result to expect.
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [TAG_W-1:0]    tag;
    logic [FTYPE_W-1:0]  ty;
    logic                typed;
    result_t             want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_LOOKUP,   32'h0,         4'h0, 1'b1, '{1'b0, 4'h0, 6'd0}},
    '{OP_QUERY,    32'h0,         4'h0, 1'b1, '{1'b0, 4'h0, 6'd0}},
    '{OP_MARK_IN,  32'h0,         4'h0, 1'b1, '{1'b0, 4'h0, 6'd0}},
    '{OP_MARK_OUT, TAG_MAX,       4'h0, 1'b1, '{1'b0, 4'h0, 6'd0}},
    '{OP_REGISTER, 32'h0,         4'h0, 1'b1, '{1'b1, 4'h0, 6'd1}},
    '{OP_REGISTER, TAG_MAX,       4'hF, 1'b1, '{1'b1, 4'h0, 6'd2}},
    '{OP_REGISTER, 32'h0,         4'h5, 1'b1, '{1'b0, 4'h0, 6'd2}},
    '{OP_LOOKUP,   TAG_MAX,       4'h0, 1'b1, '{1'b1, 4'hF, 6'd2}},
    '{OP_LOOKUP,   32'h0,         4'hF, 1'b1, '{1'b1, 4'h0, 6'd2}},
    '{OP_LOOKUP,   32'h1234_5678, 4'h0, 1'b1, '{1'b0, 4'h0, 6'd2}},
    '{OP_MARK_IN,  TAG_MAX,       4'h0, 1'b1, '{1'b1, 4'h0, 6'd2}},
    '{OP_QUERY,    32'h0,         4'hF, 1'b1, '{1'b1, 4'h0, 6'd2}},
    '{OP_QUERY,    32'h0,         4'h0, 1'b1, '{1'b0, 4'h0, 6'd2}},
    '{OP_MARK_OUT, TAG_MAX,       4'h0, 1'b1, '{1'b1, 4'h0, 6'd2}},
    '{OP_QUERY,    32'h0,         4'hF, 1'b1, '{1'b0, 4'h0, 6'd2}},
    '{OP_MARK_IN,  32'h0,         4'h0, 1'b0, '0},
    '{OP_QUERY,    TAG_MAX,       4'h0, 1'b0, '0},
    '{OP_UNDEF_LO, TAG_MAX,       4'hF, 1'b1, '{1'b0, 4'h0, 6'd2}},
    '{OP_UNDEF_HI, 32'h0,         4'h0, 1'b1, '{1'b0, 4'h0, 6'd2}},
    '{OP_REGISTER, 32'hA5A5_A5A5, 4'hA, 1'b0, '0},
    '{OP_CLEAR,    32'h0,         4'h0, 1'b1, '{1'b1, 4'h0, 6'd0}},
    '{OP_LOOKUP,   TAG_MAX,       4'h0, 1'b1, '{1'b0, 4'h0, 6'd0}},
    '{OP_REGISTER, TAG_MAX,       4'h3, 1'b1, '{1'b1, 4'h0, 6'd1}},
    '{OP_LOOKUP,   TAG_MAX,       4'h0, 1'b0, '0},
    '{OP_QUERY,    32'h0,         4'hF, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [FTYPE_W-1:0]  cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [TAG_W-1:0]    in_tag_id = '0;
  logic [FTYPE_W-1:0]  in_item_type = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_success;
  logic [FTYPE_W-1:0]  out_found_type;
  logic [ECOUNT_W-1:0] out_entry_count;

  // Typed expectation that travels with the current request.
  logic    cur_typed = 1'b0;
  result_t cur_want = '0;

  // Behavioral copy of the table.
  logic [TAG_W-1:0]     tag_tbl  [TABLE_DEPTH];
  logic [TYPE_BITS-1:0] type_tbl [TABLE_DEPTH];
  logic [LOC_W-1:0]     loc_tbl  [TABLE_DEPTH];
  int                   entries = 0;
  logic [FTYPE_W-1:0]   miss_type = '0;

  result_t          pending_results[$];
  logic [TAG_W-1:0] tag_pool[$];
  int mismatch_count = 0;
  int accepted_items = 0;
  int issued_items = 0;
  int burst_left = 1;

  tagged_item_location_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_tag_id       (in_tag_id),
    .in_item_type    (in_item_type),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_success     (out_success),
    .out_found_type  (out_found_type),
    .out_entry_count (out_entry_count)
  );

  always #5 clk = ~clk;

  // Returns the index of the first live entry holding tag, or -1.
  function automatic int find_tag(input logic [TAG_W-1:0] tag);
    for (int i = 0; i < entries; i++) begin
      if (tag_tbl[i] == tag) return i;
    end
    return -1;
  endfunction

  // Applies one request to the behavioral table and returns its result.
  function automatic result_t apply_request(input logic [OPCODE_W-1:0] op,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [FTYPE_W-1:0] ty_in);
    result_t              r;
    logic [TYPE_BITS-1:0] ty;
    int                   pos;
    r = '0;
    ty = ty_in[TYPE_BITS-1:0];
    pos = find_tag(tag);
    case (op)
      OP_CLEAR: begin
        entries = 0;
        r.success = 1'b1;
      end
      OP_REGISTER: begin
        if (pos < 0 && entries < TABLE_DEPTH) begin
          tag_tbl[entries] = tag;
          type_tbl[entries] = ty;
          loc_tbl[entries] = LOC_UNKNOWN;
          entries++;
          r.success = 1'b1;
        end
      end
      OP_MARK_IN, OP_MARK_OUT: begin
        if (pos >= 0) begin
          loc_tbl[pos] = (op == OP_MARK_IN) ? LOC_INSIDE : LOC_OUTSIDE;
          r.success = 1'b1;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < entries; i++) begin
          if (type_tbl[i] == ty && loc_tbl[i] == LOC_INSIDE) r.success = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (pos >= 0) begin
          r.found_type = FTYPE_W'(type_tbl[pos]);
          r.success = 1'b1;
        end else begin
          r.found_type = FTYPE_W'(miss_type[TYPE_BITS-1:0]);
        end
      end
      default: ;
    endcase
    r.entry_count = ECOUNT_W'(entries);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Accepted results are checked first, then accepted requests are predicted.
  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    result_t calc;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_success, out_found_type, out_entry_count};
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got.success !== want.success)
            report_mismatch($sformatf("success got %0d want %0d",
                                      got.success, want.success));
          if (got.found_type !== want.found_type)
            report_mismatch($sformatf("found_type got %0d want %0d",
                                      got.found_type, want.found_type));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        calc = apply_request(in_opcode, in_tag_id, in_item_type);
        pending_results.push_back(cur_typed ? cur_want : calc);
        accepted_items++;
      end
    end
  end

  // Sender pacing: bursts of random length, then a gap of random length.
  task automatic pace_sender();
    int g;
    int r;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      r = $urandom_range(0, 9);
      if (r < 3) g = 0;
      else if (r < 9) g = $urandom_range(1, 12);
      else g = $urandom_range(20, 40);
      if (g > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  endtask

  // Offers one request and waits for its transfer.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [TAG_W-1:0] tag,
                           input logic [FTYPE_W-1:0] ty, input logic typed,
                           input result_t want);
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_tag_id <= tag;
    in_item_type <= ty;
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk); while (in_stall);
    if (op <= OP_LOOKUP) issued_items++;
    pace_sender();
  endtask

  function automatic logic [TAG_W-1:0] fresh_tag();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return TAG_MAX;
    if (r == 2) return TAG_W'($urandom_range(0, 3));
    return $urandom;
  endfunction

  // Mostly tags that are registered, otherwise arbitrary ones.
  function automatic logic [TAG_W-1:0] pick_tag();
    if (tag_pool.size() != 0 && $urandom_range(0, 9) < 7)
      return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    return fresh_tag();
  endfunction

  // Writes the unknown type code once every result is back.
  task automatic write_miss_type(input logic [FTYPE_W-1:0] value);
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    miss_type = value;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  // One random sequence: usually clear, register a set of tags, then work on them.
  task automatic run_sequence(input bit force_fill);
    int n;
    int m;
    int r;
    logic [TAG_W-1:0]    t;
    logic [OPCODE_W-1:0] op;
    if (!force_fill && $urandom_range(0, 9) == 0) begin
      // Noise: any opcode with arbitrary fields.
      repeat ($urandom_range(1, 8)) begin
        op = OPCODE_W'($urandom_range(0, 7));
        if (op == OP_CLEAR) tag_pool.delete();
        send_item(op, pick_tag(), FTYPE_W'($urandom_range(0, 15)), 1'b0, '0);
      end
    end else begin
      if (force_fill || $urandom_range(0, 3) != 0) begin
        send_item(OP_CLEAR, $urandom, FTYPE_W'($urandom_range(0, 15)), 1'b0, '0);
        tag_pool.delete();
      end
      if (force_fill) n = TABLE_DEPTH + 2;
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 4);
      else n = $urandom_range(0, 10);
      for (int k = 0; k < n; k++) begin
        if (tag_pool.size() != 0 && $urandom_range(0, 6) == 0) begin
          t = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
        end else begin
          t = fresh_tag();
          tag_pool.push_back(t);
        end
        send_item(OP_REGISTER, t, FTYPE_W'($urandom_range(0, 15)), 1'b0, '0);
      end
      m = $urandom_range(4, 24);
      repeat (m) begin
        r = $urandom_range(0, 19);
        if (r < 6) op = OP_MARK_IN;
        else if (r < 9) op = OP_MARK_OUT;
        else if (r < 13) op = OP_QUERY;
        else if (r < 17) op = OP_LOOKUP;
        else if (r < 19) op = OP_REGISTER;
        else op = ($urandom_range(0, 1) != 0) ? OP_UNDEF_LO : OP_UNDEF_HI;
        t = pick_tag();
        if (op == OP_REGISTER) tag_pool.push_back(t);
        send_item(op, t, FTYPE_W'($urandom_range(0, 15)), 1'b0, '0);
      end
    end
  endtask

  // Receiver: stall patterns in segments, and one long hold-off.
  initial begin : receiver
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    forever begin
      if (!held && accepted_items >= LONG_HOLD_AT) begin
        held = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 40);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) != 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= k[0];
        endcase
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int               waited;
    logic [FTYPE_W-1:0] code;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].tag, DIRECTED[i].ty,
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    issued_items = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 3: code = '1;
        1: code = '0;
        default: code = FTYPE_W'($urandom_range(0, 15));
      endcase
      write_miss_type(code);
      run_sequence(p == 0);
      while (issued_items < (p + 1) * RANDOM_ITEMS / PHASES) run_sequence(1'b0);
    end

    // Drain: wait for every outstanding result, then a little longer.
    @(negedge clk) in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : watchdog
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
